### rtl/cic_pkg.sv
// Types, constants and arithmetic step functions for the circle impulse collision core.
`timescale 1ns / 1ps
`default_nettype none
package cic_pkg;

  localparam int IN_W  = 384;
  localparam int OUT_W = 128;
  localparam int CFG_W = 16;

  localparam logic [CFG_W-1:0] RESTITUTION_RESET = 16'd25600;

  // Stage map of the pipeline
  localparam int ST_IN     = 0;
  localparam int ST_ABS    = 1;
  localparam int ST_SUM    = 2;
  localparam int ST_SQ0    = 3;
  localparam int SQ_STEPS  = 32;
  localparam int DIV_STEPS = 31;
  localparam int ST_DIV0   = ST_SQ0 + SQ_STEPS;
  localparam int ST_NORM   = ST_DIV0 + DIV_STEPS;
  localparam int ST_VN     = ST_NORM + 1;
  localparam int ST_K      = ST_VN + 1;
  localparam int ST_SP     = ST_K + 1;
  localparam int ST_S      = ST_SP + 1;
  localparam int ST_DP     = ST_S + 1;
  localparam int ST_D      = ST_DP + 1;
  localparam int ST_OUT    = ST_D + 1;
  localparam int NSTAGE    = ST_OUT + 1;

  typedef struct packed {
    logic               hit;
    logic               sgnx;
    logic               sgny;
    logic               ltx;
    logic               lty;
    logic signed [32:0] dx;
    logic signed [32:0] dy;
    logic [31:0]        adx;
    logic [31:0]        ady;
    logic [63:0]        adx2;
    logic [63:0]        ady2;
    logic [31:0]        rsum;
    logic [63:0]        rsum2;
    logic signed [32:0] dvx;
    logic signed [32:0] dvy;
    logic signed [31:0] v1x;
    logic signed [31:0] v1y;
    logic signed [31:0] v2x;
    logic signed [31:0] v2y;
    logic [63:0]        sq_rem;
    logic [31:0]        root;
    logic [30:0]        m1;
    logic [30:0]        m2;
    logic [31:0]        msum;
    logic [62:0]        w1_rem;
    logic [62:0]        w2_rem;
    logic [30:0]        w1;
    logic [30:0]        w2;
    logic [62:0]        nx_rem;
    logic [62:0]        ny_rem;
    logic [30:0]        nxm;
    logic [30:0]        nym;
    logic signed [31:0] nx;
    logic signed [31:0] ny;
    logic signed [64:0] pvx;
    logic signed [64:0] pvy;
    logic signed [35:0] vn;
    logic signed [45:0] k;
    logic signed [56:0] pl_a;
    logic signed [56:0] pl_b;
    logic signed [56:0] pl_c;
    logic signed [56:0] pl_d;
    logic signed [54:0] ph_a;
    logic signed [54:0] ph_b;
    logic signed [54:0] ph_c;
    logic signed [54:0] ph_d;
    logic signed [46:0] s1;
    logic signed [46:0] s2;
    logic signed [48:0] d1x;
    logic signed [48:0] d1y;
    logic signed [48:0] d2x;
    logic signed [48:0] d2y;
  } pipe_t;

  typedef struct packed {
    logic [63:0] rem;
    logic [31:0] root;
  } sq_t;

  typedef struct packed {
    logic [62:0] rem;
    logic [30:0] quo;
  } dv_t;

  // One result bit of the square root
  function automatic sq_t sqrt_step(logic [63:0] rem, logic [31:0] root, int b);
    logic [65:0] t;
    sq_t         r;
    t = ({34'b0, root} << (b + 1)) + (66'd1 << (2 * b));
    r.rem  = rem;
    r.root = root;
    if ({2'b0, rem} >= t) begin
      r.rem  = rem - t[63:0];
      r.root = root | (32'd1 << b);
    end
    return r;
  endfunction

  // One quotient bit of a restoring division
  function automatic dv_t div_step(logic [62:0] rem, logic [31:0] dvs, logic [30:0] quo,
                                   int b);
    logic [62:0] dsh;
    dv_t         r;
    dsh   = {31'b0, dvs} << b;
    r.rem = rem;
    r.quo = quo;
    if (rem >= dsh) begin
      r.rem = rem - dsh;
      r.quo = quo | (31'd1 << b);
    end
    return r;
  endfunction

  // Low partial product: unsigned low 24 bits of a times b
  function automatic logic signed [56:0] mul_lo(logic signed [46:0] a, logic signed [31:0] b);
    logic signed [24:0] al;
    logic signed [56:0] p;
    al = {1'b0, a[23:0]};
    p  = al * b;
    return p;
  endfunction

  // High partial product: signed upper bits of a times b
  function automatic logic signed [54:0] mul_hi(logic signed [46:0] a, logic signed [31:0] b);
    logic signed [22:0] ah;
    logic signed [54:0] p;
    ah = a[46:24];
    p  = ah * b;
    return p;
  endfunction

  // Join partial products, floor divide by 2^30
  function automatic logic signed [48:0] join_q30(logic signed [54:0] ph,
                                                  logic signed [56:0] pl);
    logic signed [78:0] full;
    full = (79'(ph) <<< 24) + 79'(pl);
    return full[78:30];
  endfunction

  function automatic logic signed [31:0] sat32(logic signed [49:0] x);
    logic signed [31:0] r;
    if (x > 50'sd2147483647) begin
      r = 32'sh7fffffff;
    end else if (x < -50'sd2147483648) begin
      r = 32'sh80000000;
    end else begin
      r = x[31:0];
    end
    return r;
  endfunction

endpackage
`default_nettype wire

### rtl/circle_impulse_collision_core.sv
// Top level: pipelined impulse collision response for one pair of circles per item.
//
//  channel | ports                         | contents
//  --------+-------------------------------+-----------------------------------------------
//  in      | in_tvalid/in_tready/in_tdata  | two bodies: pos, vel, radius, mass (Q16.16)
//  out     | out_tvalid/out_tready/out_*   | updated velocities, collided flag in tuser
//  cfg     | cfg_valid/cfg_ready/cfg_data  | restitution, unsigned Q8.8
//
// One item enters per cycle when the output side keeps taking.
// Most of the pipeline is the 32-step square root and the 31-step normal division,
// each one bit per stage, plus the multiply stages that follow.
// Reset (rst_n low at a clock edge) clears the valid bits and loads restitution 100.0.
// A stalled output freezes the whole pipeline; nothing is dropped or repeated.
`timescale 1ns / 1ps
`default_nettype none
module circle_impulse_collision_core (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       in_tvalid,
  output logic                            in_tready,
  // [31:0] first_pos_x, [63:32] first_pos_y, [95:64] second_pos_x,
  // [127:96] second_pos_y, [159:128] first_vel_x, [191:160] first_vel_y,
  // [223:192] second_vel_x, [255:224] second_vel_y, [286:256] first_radius,
  // [317:287] second_radius, [348:318] first_mass, [379:349] second_mass, zero fill
  input  wire logic [cic_pkg::IN_W-1:0]   in_tdata,
  output logic                            out_tvalid,
  input  wire logic                       out_tready,
  // [31:0] new_first_vel_x, [63:32] new_first_vel_y,
  // [95:64] new_second_vel_x, [127:96] new_second_vel_y
  output logic [cic_pkg::OUT_W-1:0]       out_tdata,
  // [0] collided
  output logic [0:0]                      out_tuser,
  input  wire logic                       cfg_valid,
  output logic                            cfg_ready,
  input  wire logic [cic_pkg::CFG_W-1:0]  cfg_data
);

  logic                          adv;
  logic [cic_pkg::NSTAGE-1:0]    vld_r;
  logic [cic_pkg::NSTAGE-1:0]    vld_nxt;
  logic [cic_pkg::CFG_W-1:0]     cfg_r;
  cic_pkg::pipe_t                pipe_r   [cic_pkg::NSTAGE];
  cic_pkg::pipe_t                pipe_nxt [cic_pkg::NSTAGE];

  // Advance the whole pipe when the output slot is empty or being taken
  assign adv       = !vld_r[cic_pkg::ST_OUT] || out_tready;
  assign in_tready = adv;
  assign cfg_ready = 1'b1;

  assign vld_nxt = {vld_r[cic_pkg::NSTAGE-2:0], in_tvalid};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= cic_pkg::RESTITUTION_RESET;
    end else if (cfg_valid) begin
      cfg_r <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= vld_nxt;
    end
  end

  genvar g;
  generate
    for (g = 0; g < cic_pkg::NSTAGE; g++) begin : g_st

      always_ff @(posedge clk) begin
        if (adv) begin
          pipe_r[g] <= pipe_nxt[g];
        end
      end

      if (g == cic_pkg::ST_IN) begin : g_in
        // Capture: center and velocity differences, radius and mass sums
        always_comb begin
          cic_pkg::pipe_t q;
          q      = '0;
          q.dx   = 33'($signed(in_tdata[31:0])) - 33'($signed(in_tdata[95:64]));
          q.dy   = 33'($signed(in_tdata[63:32])) - 33'($signed(in_tdata[127:96]));
          q.v1x  = in_tdata[159:128];
          q.v1y  = in_tdata[191:160];
          q.v2x  = in_tdata[223:192];
          q.v2y  = in_tdata[255:224];
          q.dvx  = 33'($signed(in_tdata[159:128])) - 33'($signed(in_tdata[223:192]));
          q.dvy  = 33'($signed(in_tdata[191:160])) - 33'($signed(in_tdata[255:224]));
          q.rsum = 32'(in_tdata[286:256]) + 32'(in_tdata[317:287]);
          q.m1   = in_tdata[348:318];
          q.m2   = in_tdata[379:349];
          q.msum = 32'(in_tdata[348:318]) + 32'(in_tdata[379:349]);
          pipe_nxt[g] = q;
        end
      end else if (g == cic_pkg::ST_ABS) begin : g_abs
        // Magnitudes and squares; a magnitude at or above the radius sum misses
        always_comb begin
          cic_pkg::pipe_t q;
          logic [32:0]    magx;
          logic [32:0]    magy;
          q      = pipe_r[g-1];
          magx   = q.dx[32] ? 33'(-q.dx) : 33'(q.dx);
          magy   = q.dy[32] ? 33'(-q.dy) : 33'(q.dy);
          q.sgnx = q.dx[32];
          q.sgny = q.dy[32];
          q.adx  = magx[31:0];
          q.ady  = magy[31:0];
          q.ltx  = magx < {1'b0, q.rsum};
          q.lty  = magy < {1'b0, q.rsum};
          q.adx2 = q.adx * q.adx;
          q.ady2 = q.ady * q.ady;
          q.rsum2 = q.rsum * q.rsum;
          pipe_nxt[g] = q;
        end
      end else if (g == cic_pkg::ST_SUM) begin : g_sum
        // Exact overlap test; seed the root and weight dividers
        always_comb begin
          cic_pkg::pipe_t q;
          logic [64:0]    sum;
          q        = pipe_r[g-1];
          sum      = {1'b0, q.adx2} + {1'b0, q.ady2};
          q.hit    = q.ltx && q.lty && (sum < {1'b0, q.rsum2});
          q.sq_rem = sum[63:0];
          q.root   = '0;
          q.w1_rem = {2'b0, q.m1, 30'b0};
          q.w2_rem = {2'b0, q.m2, 30'b0};
          q.w1     = '0;
          q.w2     = '0;
          pipe_nxt[g] = q;
        end
      end else if (g >= cic_pkg::ST_SQ0 && g < cic_pkg::ST_DIV0) begin : g_sq
        // One root bit per stage; the mass weights divide alongside
        localparam int B  = cic_pkg::SQ_STEPS - 1 - (g - cic_pkg::ST_SQ0);
        localparam int WB = cic_pkg::DIV_STEPS - 1 - (g - cic_pkg::ST_SQ0);
        always_comb begin
          cic_pkg::pipe_t q;
          cic_pkg::sq_t   sr;
          cic_pkg::dv_t   d1;
          cic_pkg::dv_t   d2;
          q        = pipe_r[g-1];
          sr       = cic_pkg::sqrt_step(q.sq_rem, q.root, B);
          q.sq_rem = sr.rem;
          q.root   = sr.root;
          if (WB >= 0) begin
            d1       = cic_pkg::div_step(q.w1_rem, q.msum, q.w1, WB);
            d2       = cic_pkg::div_step(q.w2_rem, q.msum, q.w2, WB);
            q.w1_rem = d1.rem;
            q.w1     = d1.quo;
            q.w2_rem = d2.rem;
            q.w2     = d2.quo;
          end
          pipe_nxt[g] = q;
        end
      end else if (g >= cic_pkg::ST_DIV0 && g < cic_pkg::ST_NORM) begin : g_div
        // Normal magnitudes: |d| * 2^30 / dist, one quotient bit per stage
        localparam int B = cic_pkg::DIV_STEPS - 1 - (g - cic_pkg::ST_DIV0);
        always_comb begin
          cic_pkg::pipe_t q;
          cic_pkg::dv_t   ax;
          cic_pkg::dv_t   ay;
          q = pipe_r[g-1];
          if (g == cic_pkg::ST_DIV0) begin
            q.nx_rem = {1'b0, q.adx, 30'b0};
            q.ny_rem = {1'b0, q.ady, 30'b0};
            q.nxm    = '0;
            q.nym    = '0;
          end
          ax       = cic_pkg::div_step(q.nx_rem, q.root, q.nxm, B);
          ay       = cic_pkg::div_step(q.ny_rem, q.root, q.nym, B);
          q.nx_rem = ax.rem;
          q.nxm    = ax.quo;
          q.ny_rem = ay.rem;
          q.nym    = ay.quo;
          pipe_nxt[g] = q;
        end
      end else if (g == cic_pkg::ST_NORM) begin : g_norm
        // Sign the normal, drop it for coincident centers, drop weights for zero mass
        always_comb begin
          cic_pkg::pipe_t q;
          q    = pipe_r[g-1];
          q.nx = q.sgnx ? -$signed({1'b0, q.nxm}) : $signed({1'b0, q.nxm});
          q.ny = q.sgny ? -$signed({1'b0, q.nym}) : $signed({1'b0, q.nym});
          if (q.root == '0) begin
            q.nx = '0;
            q.ny = '0;
          end
          if (q.msum == '0) begin
            q.w1 = '0;
            q.w2 = '0;
          end
          q.pvx = q.nx * q.dvx;
          q.pvy = q.ny * q.dvy;
          pipe_nxt[g] = q;
        end
      end else if (g == cic_pkg::ST_VN) begin : g_vn
        always_comb begin
          cic_pkg::pipe_t     q;
          logic signed [65:0] sum;
          q    = pipe_r[g-1];
          sum  = 66'(q.pvx) + 66'(q.pvy);
          q.vn = sum[65:30];
          pipe_nxt[g] = q;
        end
      end else if (g == cic_pkg::ST_K) begin : g_k
        // Scale by (1 + e)
        always_comb begin
          cic_pkg::pipe_t     q;
          logic signed [17:0] ee;
          logic signed [53:0] prod;
          q    = pipe_r[g-1];
          ee   = $signed({2'b0, cfg_r} + 18'd256);
          prod = ee * q.vn;
          q.k  = prod[53:8];
          pipe_nxt[g] = q;
        end
      end else if (g == cic_pkg::ST_SP) begin : g_sp
        always_comb begin
          cic_pkg::pipe_t     q;
          logic signed [46:0] kx;
          logic signed [46:0] nk;
          logic signed [31:0] w1s;
          logic signed [31:0] w2s;
          q      = pipe_r[g-1];
          kx     = 47'(q.k);
          nk     = -kx;
          w1s    = $signed({1'b0, q.w1});
          w2s    = $signed({1'b0, q.w2});
          q.pl_a = cic_pkg::mul_lo(nk, w2s);
          q.ph_a = cic_pkg::mul_hi(nk, w2s);
          q.pl_b = cic_pkg::mul_lo(kx, w1s);
          q.ph_b = cic_pkg::mul_hi(kx, w1s);
          pipe_nxt[g] = q;
        end
      end else if (g == cic_pkg::ST_S) begin : g_s
        always_comb begin
          cic_pkg::pipe_t     q;
          logic signed [48:0] t1;
          logic signed [48:0] t2;
          q    = pipe_r[g-1];
          t1   = cic_pkg::join_q30(q.ph_a, q.pl_a);
          t2   = cic_pkg::join_q30(q.ph_b, q.pl_b);
          q.s1 = t1[46:0];
          q.s2 = t2[46:0];
          pipe_nxt[g] = q;
        end
      end else if (g == cic_pkg::ST_DP) begin : g_dp
        always_comb begin
          cic_pkg::pipe_t q;
          q      = pipe_r[g-1];
          q.pl_a = cic_pkg::mul_lo(q.s1, q.nx);
          q.ph_a = cic_pkg::mul_hi(q.s1, q.nx);
          q.pl_b = cic_pkg::mul_lo(q.s1, q.ny);
          q.ph_b = cic_pkg::mul_hi(q.s1, q.ny);
          q.pl_c = cic_pkg::mul_lo(q.s2, q.nx);
          q.ph_c = cic_pkg::mul_hi(q.s2, q.nx);
          q.pl_d = cic_pkg::mul_lo(q.s2, q.ny);
          q.ph_d = cic_pkg::mul_hi(q.s2, q.ny);
          pipe_nxt[g] = q;
        end
      end else if (g == cic_pkg::ST_D) begin : g_d
        always_comb begin
          cic_pkg::pipe_t q;
          q     = pipe_r[g-1];
          q.d1x = cic_pkg::join_q30(q.ph_a, q.pl_a);
          q.d1y = cic_pkg::join_q30(q.ph_b, q.pl_b);
          q.d2x = cic_pkg::join_q30(q.ph_c, q.pl_c);
          q.d2y = cic_pkg::join_q30(q.ph_d, q.pl_d);
          pipe_nxt[g] = q;
        end
      end else begin : g_out
        // Apply the change on a hit, saturate; pass velocities through otherwise
        always_comb begin
          cic_pkg::pipe_t q;
          q = pipe_r[g-1];
          if (q.hit) begin
            q.v1x = cic_pkg::sat32(50'(q.v1x) + 50'(q.d1x));
            q.v1y = cic_pkg::sat32(50'(q.v1y) + 50'(q.d1y));
            q.v2x = cic_pkg::sat32(50'(q.v2x) + 50'(q.d2x));
            q.v2y = cic_pkg::sat32(50'(q.v2y) + 50'(q.d2y));
          end
          pipe_nxt[g] = q;
        end
      end
    end
  endgenerate

  assign out_tvalid = vld_r[cic_pkg::ST_OUT];
  assign out_tdata  = {pipe_r[cic_pkg::ST_OUT].v2y, pipe_r[cic_pkg::ST_OUT].v2x,
                       pipe_r[cic_pkg::ST_OUT].v1y, pipe_r[cic_pkg::ST_OUT].v1x};
  assign out_tuser  = pipe_r[cic_pkg::ST_OUT].hit;

`ifndef SYNTHESIS
  // A stall freezes every valid bit
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !adv |=> $stable(vld_r))
    else $error("pipeline moved during stall");

  // Mass weights sum to one within a unit of the last place
  a_weight_sum: assert property (@(posedge clk) disable iff (!rst_n)
    (vld_r[cic_pkg::ST_DIV0-1] && pipe_r[cic_pkg::ST_DIV0-1].msum != '0) |->
      ((32'(pipe_r[cic_pkg::ST_DIV0-1].w1) + 32'(pipe_r[cic_pkg::ST_DIV0-1].w2)
        <= 32'd1073741824) &&
       (32'(pipe_r[cic_pkg::ST_DIV0-1].w1) + 32'(pipe_r[cic_pkg::ST_DIV0-1].w2)
        >= 32'd1073741823)))
    else $error("mass weights out of range");

  // Normal components never exceed one on a hit with distinct centers
  a_norm_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (vld_r[cic_pkg::ST_NORM-1] && pipe_r[cic_pkg::ST_NORM-1].hit &&
     pipe_r[cic_pkg::ST_NORM-1].root != '0) |->
      (pipe_r[cic_pkg::ST_NORM-1].nxm <= 31'd1073741824 &&
       pipe_r[cic_pkg::ST_NORM-1].nym <= 31'd1073741824))
    else $error("normal component above one");
`endif

endmodule
`default_nettype wire

### test/circle_impulse_collision_core_tb.sv
// Self-checking testbench for the circle impulse collision core.
`timescale 1ns / 1ps
module circle_impulse_collision_core_tb;

  localparam int  DRAIN_CYCLES = 90;      // more than the pipeline depth
  localparam int  CYCLE_LIMIT  = 1000000;

  // One body pair as it travels on the input stream
  typedef struct {
    logic signed [31:0] p1x, p1y, p2x, p2y;
    logic signed [31:0] v1x, v1y, v2x, v2y;
    logic [30:0]        r1, r2, m1, m2;
  } body_pair_t;

  // One response item
  typedef struct {
    logic               collided;
    logic signed [31:0] v1x, v1y, v2x, v2y;
  } response_t;

  logic                       clk = 1'b0;
  logic                       rst_n = 1'b0;
  logic                       in_tvalid = 1'b0;
  logic                       in_tready;
  logic [cic_pkg::IN_W-1:0]   in_tdata = '0;
  logic                       out_tvalid;
  logic                       out_tready = 1'b0;
  logic [cic_pkg::OUT_W-1:0]  out_tdata;
  logic [0:0]                 out_tuser;
  logic                       cfg_valid = 1'b0;
  logic                       cfg_ready;
  logic [cic_pkg::CFG_W-1:0]  cfg_data = '0;

  response_t   pending_responses[$];
  logic [15:0] restitution_q88 = cic_pkg::RESTITUTION_RESET;
  int          mismatches = 0;
  int          cycles = 0;
  int          idle_pct = 0;
  int          stall_pct = 0;

  circle_impulse_collision_core u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Guard against a hung pipeline
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // Integer square root, floor
  function automatic logic [127:0] isqrt(logic [127:0] x);
    logic [127:0] res, bitv;
    res  = '0;
    bitv = 128'd1 << 126;
    while (bitv > x) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (x >= res + bitv) begin
        x   = x - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  function automatic logic signed [31:0] clamp32(logic signed [127:0] x);
    if (x > 128'sd2147483647) return 32'sh7fffffff;
    if (x < -128'sd2147483648) return 32'sh80000000;
    return x[31:0];
  endfunction

  // Predict the response: overlap test, unit normal, impulse split by mass
  function automatic response_t predict_response(body_pair_t b, logic [15:0] e);
    logic signed [127:0] ax, ay, bx, by, dx, dy, adx, ady, rsum, root_q;
    logic signed [127:0] nx, ny, dvx, dvy, vn, k, msum, w1, w2, s1, s2, eterm;
    logic signed [127:0] u1x, u1y, u2x, u2y, m1w, m2w;
    response_t r;
    ax = b.p1x; ay = b.p1y; bx = b.p2x; by = b.p2y;
    u1x = b.v1x; u1y = b.v1y; u2x = b.v2x; u2y = b.v2y;
    dx = ax - bx;
    dy = ay - by;
    adx = (dx < 0) ? -dx : dx;
    ady = (dy < 0) ? -dy : dy;
    rsum = {97'd0, b.r1} + {97'd0, b.r2};
    r.collided = (adx * adx + ady * ady) < rsum * rsum;
    if (r.collided) begin
      root_q = isqrt(adx * adx + ady * ady);
      nx = 0;
      ny = 0;
      if (root_q != 0) begin
        nx = (adx <<< 30) / root_q;
        ny = (ady <<< 30) / root_q;
        if (dx < 0) nx = -nx;
        if (dy < 0) ny = -ny;
      end
      dvx = u1x - u2x;
      dvy = u1y - u2y;
      vn = (nx * dvx + ny * dvy) >>> 30;
      eterm = {112'd0, e};
      k = ((eterm + 256) * vn) >>> 8;
      m1w = {97'd0, b.m1};
      m2w = {97'd0, b.m2};
      msum = m1w + m2w;
      w1 = 0;
      w2 = 0;
      if (msum != 0) begin
        w1 = (m1w <<< 30) / msum;
        w2 = (m2w <<< 30) / msum;
      end
      s1 = (-k * w2) >>> 30;
      s2 = (k * w1) >>> 30;
      u1x = u1x + ((s1 * nx) >>> 30);
      u1y = u1y + ((s1 * ny) >>> 30);
      u2x = u2x + ((s2 * nx) >>> 30);
      u2y = u2y + ((s2 * ny) >>> 30);
    end
    r.v1x = clamp32(u1x);
    r.v1y = clamp32(u1y);
    r.v2x = clamp32(u2x);
    r.v2y = clamp32(u2y);
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %h want %h at cycle %0d", what, got, want, cycles);
    mismatches++;
  endtask

  // Compare every accepted response item with the oldest prediction
  always @(posedge clk) begin
    response_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_responses.size() == 0) begin
        report_mismatch("unexpected item", out_tdata[31:0], 32'd0);
      end else begin
        want = pending_responses.pop_front();
        if (out_tuser[0] !== want.collided)
          report_mismatch("collided", {31'd0, out_tuser[0]}, {31'd0, want.collided});
        if (out_tdata[31:0] !== want.v1x) report_mismatch("v1x", out_tdata[31:0], want.v1x);
        if (out_tdata[63:32] !== want.v1y) report_mismatch("v1y", out_tdata[63:32], want.v1y);
        if (out_tdata[95:64] !== want.v2x) report_mismatch("v2x", out_tdata[95:64], want.v2x);
        if (out_tdata[127:96] !== want.v2y)
          report_mismatch("v2y", out_tdata[127:96], want.v2y);
      end
    end
  end

  // Receiver: stall at the chosen rate
  always @(negedge clk) begin
    out_tready = ($urandom_range(99) >= stall_pct);
  end

  // Drive one pair, hold it until taken, then log its predicted response
  task automatic send_pair(body_pair_t b);
    @(negedge clk);
    while ($urandom_range(99) < idle_pct) begin
      in_tvalid = 1'b0;
      @(negedge clk);
    end
    in_tdata  = {4'd0, b.m2, b.m1, b.r2, b.r1, b.v2y, b.v2x, b.v1y, b.v1x,
                 b.p2y, b.p2x, b.p1y, b.p1x};
    in_tvalid = 1'b1;
    do @(posedge clk); while (!in_tready);
    pending_responses.push_back(predict_response(b, restitution_q88));
  endtask

  // Drop valid and let the pipeline empty
  task automatic drain_pipeline();
    @(negedge clk);
    in_tvalid = 1'b0;
    wait (pending_responses.size() == 0);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_restitution(logic [15:0] value);
    drain_pipeline();
    cfg_data  = value;
    cfg_valid = 1'b1;
    do @(posedge clk); while (!cfg_ready);
    restitution_q88 = value;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  function automatic logic signed [31:0] rand_scaled(int scale);
    logic signed [31:0] v;
    v = $urandom;
    return v >>> (31 - scale);
  endfunction

  // Mostly overlapping pairs with random content, some pure noise
  function automatic body_pair_t random_pair();
    body_pair_t b;
    int sc, vs;
    logic signed [31:0] dx, dy;
    if ($urandom_range(9) < 2) begin
      {b.p1x, b.p1y, b.p2x, b.p2y} = {$urandom, $urandom, $urandom, $urandom};
      {b.v1x, b.v1y, b.v2x, b.v2y} = {$urandom, $urandom, $urandom, $urandom};
      b.r1 = 31'($urandom); b.r2 = 31'($urandom);
      b.m1 = 31'($urandom); b.m2 = 31'($urandom);
      return b;
    end
    sc = $urandom_range(29, 2);
    vs = $urandom_range(31, 1);
    dx = rand_scaled(sc);
    dy = rand_scaled(sc);
    b.p1x = rand_scaled(29);
    b.p1y = rand_scaled(29);
    b.p2x = b.p1x - dx;
    b.p2y = b.p1y - dy;
    b.r1 = 31'($urandom_range(2 ** sc));
    b.r2 = 31'($urandom_range(2 ** sc));
    b.v1x = rand_scaled(vs); b.v1y = rand_scaled(vs);
    b.v2x = rand_scaled(vs); b.v2y = rand_scaled(vs);
    b.m1 = 31'($urandom >> $urandom_range(31, 1)) | 31'd1;
    b.m2 = 31'($urandom >> $urandom_range(31, 1)) | 31'd1;
    if ($urandom_range(19) == 0) b.m1 = '0;
    return b;
  endfunction

  function automatic body_pair_t make_pair(logic signed [31:0] p1x, p1y, p2x, p2y,
                                           logic signed [31:0] v1x, v1y, v2x, v2y,
                                           logic [30:0] r1, r2, m1, m2);
    body_pair_t b;
    b.p1x = p1x; b.p1y = p1y; b.p2x = p2x; b.p2y = p2y;
    b.v1x = v1x; b.v1y = v1y; b.v2x = v2x; b.v2y = v2y;
    b.r1 = r1; b.r2 = r2; b.m1 = m1; b.m2 = m2;
    return b;
  endfunction

  // Edge pairs: separated, touching, coincident, zero radii and masses, saturation
  task automatic test_edge_pairs();
    localparam logic signed [31:0] ONE = 32'sh0001_0000;
    localparam logic signed [31:0] MAXP = 32'sh7fffffff;
    localparam logic signed [31:0] MINN = 32'sh80000000;
    localparam logic [30:0] RMAX = 31'h7fffffff;
    localparam logic [30:0] R1 = 31'h0001_0000;
    localparam logic [30:0] R2 = 31'h0002_0000;
    localparam logic [30:0] R4 = 31'h0004_0000;
    send_pair(make_pair(0, 0, 5 * ONE, 0, ONE, 0, -ONE, 0, R1, R1, R1, R1));
    send_pair(make_pair(0, 0, 2 * ONE, 0, ONE, 0, -ONE, 0, R1, R1, R1, R1));
    send_pair(make_pair(0, 0, ONE, 0, ONE, 0, -ONE, 0, R1, R1, R1, R1));
    send_pair(make_pair(ONE, ONE, 0, 0, -ONE, -ONE, ONE, ONE, R1, R1, R1, R2));
    send_pair(make_pair(ONE, ONE, ONE, ONE, ONE, 2, 3, 4, R1, 0, R1, R1));
    send_pair(make_pair(ONE, ONE, ONE, ONE, ONE, 2, 3, 4, 0, 0, R1, R1));
    send_pair(make_pair(0, 0, ONE, ONE, ONE, 0, 0, ONE, R4, R1, 0, 0));
    send_pair(make_pair(0, 0, ONE, 0, ONE, 0, 0, 0, R1, R1, 0, R1));
    send_pair(make_pair(0, 0, 0, ONE, ONE, ONE, 0, 0, R1, R1, R1, 0));
    send_pair(make_pair(MAXP, MAXP, MINN, MINN, MAXP, MAXP, MINN, MINN,
                        RMAX, RMAX, RMAX, RMAX));
    send_pair(make_pair(MINN, MAXP, MAXP, MINN, MINN, MINN, MAXP, MAXP,
                        RMAX, RMAX, 1, RMAX));
    send_pair(make_pair(0, 0, 1, 0, MAXP, MINN, MINN, MAXP, RMAX, RMAX, 1, 1));
    send_pair(make_pair(0, 0, -1, -1, MINN, MINN, MAXP, MAXP, 1, 1, RMAX, 1));
    send_pair(make_pair(MAXP, MINN, MAXP, MINN, MAXP, MINN, MINN, MAXP,
                        RMAX, 0, RMAX, RMAX));
    send_pair(make_pair(-1, -1, -1, -1, -1, -1, -1, -1, RMAX, RMAX, RMAX, RMAX));
    send_pair(make_pair(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
  endtask

  // Sweep restitution through extremes, a few items at each setting
  task automatic test_restitution_sweep();
    logic [15:0] settings[5];
    settings = '{16'd0, 16'hffff, 16'd256, cic_pkg::RESTITUTION_RESET, 16'h0000};
    settings[4] = 16'($urandom);
    foreach (settings[i]) begin
      write_restitution(settings[i]);
      repeat (20) send_pair(random_pair());
    end
  endtask

  // Random pairs under each flow-control mix, with one full pause midway and one restitution change
  task automatic test_random_flow();
    int phase_idle[4] = '{0, 69, 0, 19};
    int phase_stall[4] = '{0, 0, 69, 19};
    for (int ph = 0; ph < 4; ph++) begin
      idle_pct  = phase_idle[ph];
      stall_pct = phase_stall[ph];
      repeat (60) send_pair(random_pair());
      if (ph == 1) begin
        // hold off until every response is back
        @(negedge clk);
        in_tvalid = 1'b0;
        wait (pending_responses.size() == 0);
      end
      repeat (60) send_pair(random_pair());
      if (ph == 2) write_restitution(16'($urandom));
    end
    idle_pct  = 0;
    stall_pct = 0;
  endtask

  initial begin
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    test_edge_pairs();
    test_restitution_sweep();
    test_random_flow();
    drain_pipeline();
    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
